// ===== rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
package skt_pkg;

    localparam int DEPTH_DEFAULT = 1024;
    localparam int KEY_W         = 14;
    localparam int HEIGHT_W      = 8;
    localparam int PAYLOAD_W     = HEIGHT_W + 1;
    localparam int STATUS_W      = 3;
    localparam int POS_W         = 10;
    localparam int COUNT_W       = 11;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 8;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN_RESET = 8'd100;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX_RESET = 8'd200;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_UPDATE = 2'd2,
        ACT_DELETE = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_HEIGHT    = 3'd4
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX = 1'd1;

    typedef struct packed {
        logic [1:0]          action;
        logic [KEY_W-1:0]    key;
        logic                vaccinated;
        logic [HEIGHT_W-1:0] height_cm;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic                found_vaccinated;
        logic [HEIGHT_W-1:0] found_height_cm;
        logic [COUNT_W-1:0]  entry_count;
    } rsp_t;

endpackage

// ===== rtl/skt_stream_if.sv =====
// Valid/ready channel carrying one item of type T.
interface skt_stream_if #(parameter type T = logic) (input logic clk);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sorted_key_table_core.sv =====
// Sorted key table: binary search and shifting insert/delete over one memory.
//
//  channel | dir | payload
//  --------+-----+--------------------------------------------
//  req     | in  | action, key, vaccinated, height_cm
//  rsp     | out | status, position, found_vaccinated,
//          |     | found_height_cm, entry_count
//  cfg     | in  | cfg_we, cfg_idx, cfg_data (no read-back)
//
// Each search step is one registered read of the table memory. Insert and
// delete read then write each entry moved on the single memory port. Reset
// clears the count and sets the height bounds to their reset values; the
// table memory has no clearing pass.
// A new request is taken once the previous result has left the output register.
module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)(
    input  logic                  clk,
    input  logic                  rst_n,
    skt_stream_if.sink            req,
    skt_stream_if.source          rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = KEY_W + PAYLOAD_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SREAD  = 8'b0000_0010,
        S_SCMP   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_MREAD  = 8'b0001_0000,
        S_MWRITE = 8'b0010_0000,
        S_FINAL  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    logic [EW-1:0] mem [DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [EW-1:0] mem_wdata;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [CW-1:0] idx_reg, idx_next;
    logic [HEIGHT_W-1:0] hmin_reg, hmax_reg;
    logic height_ok;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hmin_reg <= HEIGHT_MIN_RESET;
            hmax_reg <= HEIGHT_MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_HEIGHT_MIN: hmin_reg <= cfg_data;
                REG_HEIGHT_MAX: hmax_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign height_ok = (req_reg.height_cm >= hmin_reg) && (req_reg.height_cm <= hmax_reg);

    assign req.ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        mem_we         = 1'b0;
        mem_addr       = mid[AW-1:0];
        mem_wdata      = rd_data_reg;
        if (rsp_valid_reg && rsp.ready)
            rsp_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    req_next   = req.data;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    rsp_next   = '0;
                    state_next = S_SREAD;
                end
            end
            S_SREAD:
            begin
                // Address mid is presented; the data arrives next cycle.
                if (lo_reg < hi_reg)
                    state_next = S_SCMP;
                else
                begin
                    mem_addr   = lo_reg[AW-1:0];
                    state_next = S_DECIDE;
                end
            end
            S_SCMP:
            begin
                if (rd_data_reg[EW-1 -: KEY_W] < req_reg.key)
                    lo_next = mid + 1'b1;
                else
                    hi_next = mid;
                state_next = S_SREAD;
            end
            S_DECIDE:
            begin
                // rd_data_reg holds entry lo, meaningful only when lo < count.
                logic hit;
                hit = (lo_reg < count_reg) && (rd_data_reg[EW-1 -: KEY_W] == req_reg.key);
                state_next = S_OUT;
                case (action_t'(req_reg.action))
                    ACT_INSERT:
                    begin
                        if (count_reg >= CW'(DEPTH))
                            rsp_next.status = ST_FULL;
                        else if (hit)
                        begin
                            rsp_next.status           = ST_DUPLICATE;
                            rsp_next.position         = POS_W'(lo_reg);
                            rsp_next.found_vaccinated = rd_data_reg[HEIGHT_W];
                            rsp_next.found_height_cm  = rd_data_reg[HEIGHT_W-1:0];
                        end
                        else if (!height_ok)
                            rsp_next.status = ST_HEIGHT;
                        else
                        begin
                            rsp_next.position         = POS_W'(lo_reg);
                            rsp_next.found_vaccinated = req_reg.vaccinated;
                            rsp_next.found_height_cm  = req_reg.height_cm;
                            idx_next   = count_reg;
                            state_next = (count_reg > lo_reg) ? S_MREAD : S_FINAL;
                        end
                    end
                    default:
                    begin
                        if (!hit)
                            rsp_next.status = ST_NOT_FOUND;
                        else
                        begin
                            rsp_next.position         = POS_W'(lo_reg);
                            rsp_next.found_vaccinated = rd_data_reg[HEIGHT_W];
                            rsp_next.found_height_cm  = rd_data_reg[HEIGHT_W-1:0];
                            if (action_t'(req_reg.action) == ACT_UPDATE)
                            begin
                                if (!height_ok)
                                    rsp_next.status = ST_HEIGHT;
                                else
                                begin
                                    rsp_next.found_vaccinated = req_reg.vaccinated;
                                    rsp_next.found_height_cm  = req_reg.height_cm;
                                    state_next = S_FINAL;
                                end
                            end
                            else if (action_t'(req_reg.action) == ACT_DELETE)
                            begin
                                idx_next   = lo_reg;
                                state_next = (lo_reg + 1'b1 < count_reg) ? S_MREAD : S_FINAL;
                            end
                        end
                    end
                endcase
            end
            S_MREAD:
            begin
                // Read the neighbor that moves into slot idx.
                if (action_t'(req_reg.action) == ACT_INSERT)
                    mem_addr = AW'(idx_reg - 1'b1);
                else
                    mem_addr = AW'(idx_reg + 1'b1);
                state_next = S_MWRITE;
            end
            S_MWRITE:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg[AW-1:0];
                mem_wdata = rd_data_reg;
                state_next = S_MREAD;
                if (action_t'(req_reg.action) == ACT_INSERT)
                begin
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg - 1'b1 == lo_reg)
                        state_next = S_FINAL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 2'd2 >= count_reg)
                        state_next = S_FINAL;
                end
            end
            S_FINAL:
            begin
                case (action_t'(req_reg.action))
                    ACT_INSERT:
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = lo_reg[AW-1:0];
                        mem_wdata  = {req_reg.key, req_reg.vaccinated, req_reg.height_cm};
                        count_next = count_reg + 1'b1;
                    end
                    ACT_UPDATE:
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = lo_reg[AW-1:0];
                        mem_wdata  = {req_reg.key, req_reg.vaccinated, req_reg.height_cm};
                    end
                    ACT_DELETE: count_next = count_reg - 1'b1;
                    default: ;
                endcase
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_next.entry_count = COUNT_W'(count_reg);
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        idx_reg <= idx_next;
    end

endmodule

// ===== rtl/skt_checker.sv =====
// Port-level checks for the sorted key table, bound to sorted_key_table_core.
module skt_checker
    import skt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp_data
);
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.status <= ST_HEIGHT)
        else $error("status code out of range");

    a_no_ready_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while one is in progress");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == ST_FULL || rsp_data.status == ST_NOT_FOUND)
        |-> rsp_data.position == '0 && rsp_data.found_height_cm == '0)
        else $error("failed request shows entry fields");
endmodule

bind sorted_key_table_core skt_checker u_skt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
